@@ rtl/integer_range_list_parser_defines.svh @@
// ---------------------------------------------------------------------------
// Range list parser assertion macros
// Shared property forms for the concurrent checks of the parser.
// ---------------------------------------------------------------------------
`ifndef INTEGER_RANGE_LIST_PARSER_DEFINES_SVH
`define INTEGER_RANGE_LIST_PARSER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define IRLP_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define IRLP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/irlp_pkg.sv @@
// ---------------------------------------------------------------------------
// Range list parser package
// Item types, character codes, result kinds and sizing constants.
// ---------------------------------------------------------------------------
package irlp_pkg;

  localparam int unsigned FIELD_BITS     = 31;
  localparam int unsigned VALUE_BITS_DEF = 31;
  localparam int unsigned RES_DEPTH_DEF  = 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    KIND_RANGE = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_START = 2'd1,
    PH_END   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [FIELD_BITS-1:0] range_start;
    logic [FIELD_BITS-1:0] range_end;
    logic                  last;
  } out_item_t;

  // results made by one item, first one goes out first
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } res_pair_t;

endpackage

@@ rtl/irlp_core.sv @@
// ---------------------------------------------------------------------------
// Range list parser core
// Parse state registers and the per-character next-state and result logic.
// ---------------------------------------------------------------------------
module irlp_core #(
  parameter int unsigned VALUE_BITS = irlp_pkg::VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  irlp_pkg::in_item_t  item_i,
  output irlp_pkg::res_pair_t push_o
);
  import irlp_pkg::*;

  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  phase_e                phase_q, phase_d;
  logic [VALUE_BITS-1:0] start_q, start_d;
  logic [VALUE_BITS-1:0] end_q, end_d;
  logic                  open_q, open_d;
  logic                  failed_q, failed_d;

  logic                  is_digit;
  logic [3:0]            digit;
  logic [VALUE_BITS-1:0] end_base;
  logic [VALUE_BITS-1:0] pend_end;

  function automatic logic [VALUE_BITS-1:0] acc_digit(input logic [VALUE_BITS-1:0] v,
                                                      input logic [3:0] d);
    logic [VALUE_BITS+3:0] n;
    n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{VALUE_BITS{1'b0}}, d};
    if (n > {4'b0, VMAX}) begin
      return VMAX;
    end
    return n[VALUE_BITS-1:0];
  endfunction

  function automatic out_item_t make_range(input logic [VALUE_BITS-1:0] s,
                                           input logic [VALUE_BITS-1:0] e,
                                           input logic last);
    out_item_t r;
    r.kind        = KIND_RANGE;
    r.range_start = FIELD_BITS'(s);
    r.range_end   = FIELD_BITS'(e);
    r.last        = last;
    return r;
  endfunction

  assign is_digit   = (item_i.char_code >= CH_ZERO) && (item_i.char_code <= CH_NINE);
  assign digit      = 4'(item_i.char_code - CH_ZERO);
  assign pend_end   = open_q ? VMAX : end_q;
  assign end_base   = open_q ? '0 : end_q;

  always_comb begin
    out_item_t status;
    phase_d  = phase_q;
    start_d  = start_q;
    end_d    = end_q;
    open_d   = open_q;
    failed_d = failed_q;
    push_o   = '0;

    status             = '0;
    status.kind        = failed_q ? KIND_ERROR : KIND_OK;
    status.last        = 1'b1;

    if (item_i.end_of_text) begin
      // flush pending range, report status, start over
      if (!failed_q && phase_q != PH_NONE) begin
        push_o.count  = 2'd2;
        push_o.first  = make_range(start_q, pend_end, 1'b0);
        push_o.second = status;
      end else begin
        push_o.count = 2'd1;
        push_o.first = status;
      end
      phase_d  = PH_NONE;
      start_d  = '0;
      end_d    = '0;
      open_d   = 1'b0;
      failed_d = 1'b0;
    end else if (!failed_q) begin
      priority if (is_digit) begin
        unique case (phase_q)
          PH_NONE: begin
            phase_d = PH_START;
            start_d = acc_digit('0, digit);
            end_d   = acc_digit('0, digit);
          end
          PH_START: begin
            start_d = acc_digit(start_q, digit);
            end_d   = acc_digit(start_q, digit);
          end
          PH_END: begin
            open_d = 1'b0;
            end_d  = acc_digit(end_base, digit);
          end
          default: begin
            // unused phase code: behaves as end phase without updates
          end
        endcase
      end else if (item_i.char_code == CH_COMMA) begin
        if (phase_q != PH_NONE) begin
          push_o.count = 2'd1;
          push_o.first = make_range(start_q, pend_end, 1'b1);
          phase_d      = PH_NONE;
          open_d       = 1'b0;
        end
      end else if (item_i.char_code == CH_DASH) begin
        unique case (phase_q)
          PH_NONE: begin
            start_d = '0;
            end_d   = '0;
            open_d  = 1'b1;
            phase_d = PH_END;
          end
          PH_START: begin
            end_d   = '0;
            open_d  = 1'b1;
            phase_d = PH_END;
          end
          default: begin
            failed_d = 1'b1;
          end
        endcase
      end else if (item_i.char_code == CH_SPACE || item_i.char_code == CH_TAB) begin
        // blanks are skipped
      end else begin
        failed_d = 1'b1;
      end
    end

    if (!fire_i) begin
      push_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_NONE;
      start_q  <= '0;
      end_q    <= '0;
      open_q   <= 1'b0;
      failed_q <= 1'b0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      start_q  <= start_d;
      end_q    <= end_d;
      open_q   <= open_d;
      failed_q <= failed_d;
    end
  end

endmodule

@@ rtl/irlp_res_queue.sv @@
// ---------------------------------------------------------------------------
// Range list parser result queue
// Small register queue taking up to two results a cycle, one out a cycle.
// ---------------------------------------------------------------------------
module irlp_res_queue #(
  parameter int unsigned DEPTH = irlp_pkg::RES_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  irlp_pkg::res_pair_t           push_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output irlp_pkg::out_item_t           item_o,
  output logic [$clog2(DEPTH+1)-1:0]    count_o
);
  import irlp_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  out_item_t         mem_q [DEPTH];
  logic [PW-1:0]     wp_q, wp_d, rp_q, rp_d, wp_next;
  logic [CW-1:0]     cnt_q, cnt_d;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wp_next = inc(wp_q);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rp_q];
  assign count_o = cnt_q;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q + CW'(push_i.count);
    if (push_i.count == 2'd1) begin
      wp_d = wp_next;
    end else if (push_i.count == 2'd2) begin
      wp_d = inc(wp_next);
    end
    if (pop_i && valid_o) begin
      rp_d  = inc(rp_q);
      cnt_d = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wp_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wp_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/integer_range_list_parser.sv @@
// ---------------------------------------------------------------------------
// Integer range list parser
// Parses a character stream of comma separated integer ranges.
// ---------------------------------------------------------------------------
// an accepted item is held in the input register; its results are then written into the result queue
// throughput: one item per cycle while the result queue has room; an end-of-text item may put out two results
// the result queue admits a parsed item only with room for two results
// reset clears the parse state, the input valid flag and the result queue
`include "integer_range_list_parser_defines.svh"

module integer_range_list_parser #(
  parameter int unsigned VALUE_BITS = irlp_pkg::VALUE_BITS_DEF,
  parameter int unsigned RES_DEPTH  = irlp_pkg::RES_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  irlp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output irlp_pkg::out_item_t out_item_o
);
  import irlp_pkg::*;

  localparam int unsigned CW = $clog2(RES_DEPTH+1);

  logic      in_valid_q;
  in_item_t  in_q;
  logic      fire;
  logic      room;
  res_pair_t push;
  logic [CW-1:0] q_count;

  assign room       = (q_count <= CW'(RES_DEPTH - 2));
  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  irlp_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(in_q),
    .push_o(push)
  );

  irlp_res_queue #(
    .DEPTH(RES_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (out_ready_i),
    .valid_o(out_valid_o),
    .item_o (out_item_o),
    .count_o(q_count)
  );

  `IRLP_ASSERT_NOW(a_queue_bound, clk_i, rst_ni, 1'b1, q_count <= CW'(RES_DEPTH), "result queue overflow")
  `IRLP_ASSERT_NOW(a_status_last, clk_i, rst_ni, out_valid_o && out_item_o.kind != KIND_RANGE, out_item_o.last, "status item without last")
  `IRLP_ASSERT_NOW(a_kind_legal, clk_i, rst_ni, out_valid_o, out_item_o.kind == KIND_RANGE || out_item_o.kind == KIND_OK || out_item_o.kind == KIND_ERROR, "illegal result kind")
  `IRLP_ASSERT_NEXT(a_eot_pushes, clk_i, rst_ni, fire && in_q.end_of_text, out_valid_o, "end of text gave no result")

endmodule
